@@ design/command_frame_parser_assert.svh @@
// Assertion macros shared by the command frame parser RTL.
// Expects clk and arst_n in the scope where the macros are used.
`ifndef COMMAND_FRAME_PARSER_ASSERT_SVH
`define COMMAND_FRAME_PARSER_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define CFP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define CFP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/cfp_pkg.sv @@
// Types and constants for the command frame parser.
// No dependencies; used by cfp_cfg_if and all modules.
`default_nettype none

package cfp_pkg;

	localparam logic [7:0] HDR_FIRST_RST  = 8'hFE;
	localparam logic [7:0] HDR_SECOND_RST = 8'hFC;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_HEADER_FIRST  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEADER_SECOND = 1'd1;

	typedef enum logic [4:0] {
		ST_HUNT1 = 5'b00001,
		ST_HUNT2 = 5'b00010,
		ST_CMD   = 5'b00100,
		ST_LEN   = 5'b01000,
		ST_PARAM = 5'b10000
	} parse_state_t;

	typedef struct packed {
		logic [7:0] first;
		logic [7:0] second;
	} hdr_cfg_t;

	typedef struct packed {
		logic [7:0] frame_command;
		logic [7:0] frame_length;
		logic       has_param;
		logic [7:0] param_byte;
		logic [7:0] param_index;
		logic       frame_last;
	} frame_result_t;

endpackage

`default_nettype wire

@@ design/cfp_rx_if.sv @@
// Receive byte channel: valid/ready plus one received byte per beat.
// No dependencies.
`default_nettype none

interface cfp_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

@@ design/cfp_frame_if.sv @@
// Frame result channel: valid/ready plus one parsed frame beat.
// No dependencies.
`default_nettype none

interface cfp_frame_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_command;
	logic [7:0] frame_length;
	logic       has_param;
	logic [7:0] param_byte;
	logic [7:0] param_index;
	logic       frame_last;

	modport source (
		output valid, output frame_command, output frame_length, output has_param,
		output param_byte, output param_index, output frame_last, input ready
	);
	modport sink (
		input valid, input frame_command, input frame_length, input has_param,
		input param_byte, input param_index, input frame_last, output ready
	);
endinterface

`default_nettype wire

@@ design/cfp_cfg_if.sv @@
// Configuration write channel: register index and write data per beat.
// Depends on cfp_pkg for the index width.
`default_nettype none

interface cfp_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [cfp_pkg::CFG_IDX_W-1:0] reg_index;
	logic [7:0]                    wdata;

	modport source (output valid, output reg_index, output wdata, input ready);
	modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

@@ design/cfp_cfg_regs.sv @@
// Header delimiter registers written through the configuration channel.
// Depends on cfp_pkg and cfp_cfg_if.
`default_nettype none

module cfp_cfg_regs (
	input  wire logic        clk,
	input  wire logic        arst_n,
	cfp_cfg_if.sink          cfg,
	output cfp_pkg::hdr_cfg_t hdr
);

	logic [7:0] hdr_first_q;
	logic [7:0] hdr_second_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_first_q  <= cfp_pkg::HDR_FIRST_RST;
			hdr_second_q <= cfp_pkg::HDR_SECOND_RST;
		end else if (cfg.valid) begin
			case (cfg.reg_index)
				cfp_pkg::REG_HEADER_FIRST:  hdr_first_q  <= cfg.wdata;
				cfp_pkg::REG_HEADER_SECOND: hdr_second_q <= cfg.wdata;
				default: ;
			endcase
		end
	end

	assign hdr.first  = hdr_first_q;
	assign hdr.second = hdr_second_q;

endmodule

`default_nettype wire

@@ design/cfp_parse_fsm.sv @@
// Frame parse state machine: header hunt, command, length, parameter bytes.
// Depends on cfp_pkg.
`default_nettype none

module cfp_parse_fsm (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            fire,
	input  wire logic [7:0]      rx_byte,
	input  wire cfp_pkg::hdr_cfg_t hdr,
	output logic                 res_valid,
	output cfp_pkg::frame_result_t res
);

	cfp_pkg::parse_state_t state_q, state_d;
	logic [7:0] command_q, command_d;
	logic [7:0] length_q, length_d;
	logic [7:0] index_q, index_d;
	logic       param_done;

	// final parameter byte when index + 1 reaches the announced length
	assign param_done = ({1'b0, index_q} + 9'd1) >= {1'b0, length_q};

	always_comb begin
		state_d   = state_q;
		command_d = command_q;
		length_d  = length_q;
		index_d   = index_q;
		res_valid = 1'b0;
		res       = '0;
		res.frame_command = command_q;
		res.frame_length  = length_q;
		case (state_q)
			cfp_pkg::ST_HUNT2: begin
				state_d = (rx_byte == hdr.second) ? cfp_pkg::ST_CMD : cfp_pkg::ST_HUNT1;
			end
			cfp_pkg::ST_CMD: begin
				command_d = rx_byte;
				state_d   = cfp_pkg::ST_LEN;
			end
			cfp_pkg::ST_LEN: begin
				length_d = rx_byte;
				index_d  = '0;
				res.frame_length = rx_byte;
				if (rx_byte == 8'd0) begin
					state_d        = cfp_pkg::ST_HUNT1;
					res_valid      = 1'b1;
					res.frame_last = 1'b1;
				end else begin
					state_d = cfp_pkg::ST_PARAM;
				end
			end
			cfp_pkg::ST_PARAM: begin
				index_d         = index_q + 8'd1;
				res_valid       = 1'b1;
				res.has_param   = 1'b1;
				res.param_byte  = rx_byte;
				res.param_index = index_q;
				res.frame_last  = param_done;
				if (param_done) begin
					state_d = cfp_pkg::ST_HUNT1;
				end
			end
			default: begin
				state_d = (rx_byte == hdr.first) ? cfp_pkg::ST_HUNT2 : cfp_pkg::ST_HUNT1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= cfp_pkg::ST_HUNT1;
			command_q <= '0;
			length_q  <= '0;
			index_q   <= '0;
		end else if (fire) begin
			state_q   <= state_d;
			command_q <= command_d;
			length_q  <= length_d;
			index_q   <= index_d;
		end
	end

endmodule

`default_nettype wire

@@ design/cfp_out_stage.sv @@
// Result register driving the frame output channel.
// Depends on cfp_pkg and cfp_frame_if.
`default_nettype none

module cfp_out_stage (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire cfp_pkg::frame_result_t res,
	output logic                   can_load,
	cfp_frame_if.source            frame
);

	logic                   out_valid_q;
	cfp_pkg::frame_result_t res_q;

	assign can_load = !out_valid_q || frame.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (can_load) begin
			out_valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && can_load) begin
			res_q <= res;
		end
	end

	assign frame.valid         = out_valid_q;
	assign frame.frame_command = res_q.frame_command;
	assign frame.frame_length  = res_q.frame_length;
	assign frame.has_param     = res_q.has_param;
	assign frame.param_byte    = res_q.param_byte;
	assign frame.param_index   = res_q.param_index;
	assign frame.frame_last    = res_q.frame_last;

endmodule

`default_nettype wire

@@ design/command_frame_parser.sv @@
// Command frame parser top level: input register, parse FSM, result register.
// Depends on cfp_pkg, the cfp_*_if interfaces, cfp_cfg_regs, cfp_parse_fsm,
// cfp_out_stage and command_frame_parser_assert.svh.
//
//   channel | dir | beat contents
//   rx      | in  | rx_byte
//   frame   | out | frame_command, frame_length, has_param, param_byte,
//           |     | param_index, frame_last
//   cfg     | in  | reg_index (0 header_first, 1 header_second), wdata
//
// One byte per cycle unless the frame output stalls; each result passes the
// input register, then the result register fed by the parse FSM.
// A stalled frame output holds the result register and, through it, the
// input register; bytes that give no result also wait in that case.
// arst_n resets the FSM to header hunt and the headers to 0xFE, 0xFC.
`default_nettype none

module command_frame_parser (
	input  wire logic   clk,
	input  wire logic   arst_n,
	cfp_rx_if.sink      rx,
	cfp_frame_if.source frame,
	cfp_cfg_if.sink     cfg
);

	`include "command_frame_parser_assert.svh"

	cfp_pkg::hdr_cfg_t      hdr;
	cfp_pkg::frame_result_t res;
	logic                   res_valid;
	logic                   can_load;
	logic                   advance;
	logic                   valid_s1;
	logic [7:0]             rx_byte_s1;

	cfp_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.hdr    (hdr)
	);

	assign advance  = valid_s1 && can_load;
	assign rx.ready = !valid_s1 || can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			rx_byte_s1 <= rx.rx_byte;
		end
	end

	cfp_parse_fsm u_fsm (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (advance),
		.rx_byte   (rx_byte_s1),
		.hdr       (hdr),
		.res_valid (res_valid),
		.res       (res)
	);

	cfp_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance && res_valid),
		.res      (res),
		.can_load (can_load),
		.frame    (frame)
	);

	`CFP_ASSERT_NOW(a_empty_frame, frame.valid && !frame.has_param,
		frame.frame_last && frame.param_byte == 8'd0 && frame.param_index == 8'd0,
		"empty frame beat carries parameter data or lacks last")

	`CFP_ASSERT_NOW(a_mid_index, frame.valid && frame.has_param && !frame.frame_last,
		({1'b0, frame.param_index} + 9'd1) < {1'b0, frame.frame_length},
		"non-final parameter index at or past frame length")

	`CFP_ASSERT_NEXT(a_s1_hold, valid_s1 && !can_load,
		valid_s1 && $stable(rx_byte_s1),
		"input register changed while result register stalled")

endmodule

`default_nettype wire
